>>> rtl/crc8fr_pkg.sv
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared types, constants and the CRC-8 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

    // Reflected CRC-8 polynomial and header bytes
    localparam logic [7:0] CRC_POLY    = 8'h8C;
    localparam logic [7:0] HDR0        = 8'h55;
    localparam logic [7:0] HDR1        = 8'hAA;
    localparam logic [7:0] CAPTURE_LEN = 8'd5;

    // Result status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    // Receiver phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN     = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC     = 3'd3,
        PH_TRAIL0  = 3'd4,
        PH_TRAIL1  = 3'd5
    } phase_t;

    // One result transaction from the parser
    typedef struct packed {
        logic        valid;
        logic [15:0] left_speed;
        logic [15:0] right_speed;
        logic [7:0]  ctrl_flag;
        logic        status;
    } result_t;

    // Advance the CRC by one byte, LSB first
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // CRC after both header bytes, from init zero
    localparam logic [7:0] CRC_AFTER_HDR = crc_byte(crc_byte(8'h00, HDR0), HDR1);

endpackage

>>> rtl/crc8fr_parser.sv
// ----------------------------------------------------------------------------
// crc8fr_parser
// Frame state machine: header hunt, length, payload capture, CRC check and
// trailer skip. Updates its state on each step and reports the result that
// the current byte causes.
// ----------------------------------------------------------------------------
module crc8fr_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    output crc8fr_pkg::result_t    result
);

    crc8fr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] previous_byte_reg, previous_byte_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] payload_count_reg, payload_count_next;
    logic [7:0] running_crc_reg, running_crc_next;
    logic [7:0] captured_reg [5];
    logic [7:0] crc_upd;
    logic [7:0] count_inc;

    assign crc_upd   = crc8fr_pkg::crc_byte(running_crc_reg, rx_byte);
    assign count_inc = payload_count_reg + 8'd1;

    // Next state of the frame tracker
    always_comb
    begin
        phase_next         = phase_reg;
        previous_byte_next = previous_byte_reg;
        frame_length_next  = frame_length_reg;
        payload_count_next = payload_count_reg;
        running_crc_next   = running_crc_reg;
        unique case (phase_reg)
            crc8fr_pkg::PH_LEN:
            begin
                frame_length_next  = rx_byte;
                running_crc_next   = crc_upd;
                payload_count_next = 8'd0;
                phase_next = (rx_byte == 8'd0) ? crc8fr_pkg::PH_CRC : crc8fr_pkg::PH_PAYLOAD;
            end
            crc8fr_pkg::PH_PAYLOAD:
            begin
                running_crc_next   = crc_upd;
                payload_count_next = count_inc;
                if (count_inc >= frame_length_reg)
                begin
                    phase_next = crc8fr_pkg::PH_CRC;
                end
            end
            crc8fr_pkg::PH_CRC:
            begin
                if (rx_byte != running_crc_reg)
                begin
                    phase_next         = crc8fr_pkg::PH_HUNT;
                    previous_byte_next = 8'd0;
                    frame_length_next  = 8'd0;
                    payload_count_next = 8'd0;
                    running_crc_next   = 8'd0;
                end
                else
                begin
                    phase_next = crc8fr_pkg::PH_TRAIL0;
                end
            end
            crc8fr_pkg::PH_TRAIL0:
            begin
                phase_next = crc8fr_pkg::PH_TRAIL1;
            end
            crc8fr_pkg::PH_TRAIL1:
            begin
                phase_next         = crc8fr_pkg::PH_HUNT;
                previous_byte_next = 8'd0;
                frame_length_next  = 8'd0;
                payload_count_next = 8'd0;
                running_crc_next   = 8'd0;
            end
            default:
            begin
                // Hunt; a repeated 0xaa never replaces the remembered byte
                if (rx_byte == crc8fr_pkg::HDR1)
                begin
                    if (previous_byte_reg == crc8fr_pkg::HDR0)
                    begin
                        phase_next         = crc8fr_pkg::PH_LEN;
                        running_crc_next   = crc8fr_pkg::CRC_AFTER_HDR;
                        payload_count_next = 8'd0;
                    end
                end
                else
                begin
                    previous_byte_next = rx_byte;
                end
            end
        endcase
    end

    // Result caused by the current byte
    always_comb
    begin
        result = '0;
        unique case (phase_reg)
            crc8fr_pkg::PH_CRC:
            begin
                if (rx_byte != running_crc_reg)
                begin
                    result.valid  = 1'b1;
                    result.status = crc8fr_pkg::STATUS_CRC_ERR;
                end
            end
            crc8fr_pkg::PH_TRAIL1:
            begin
                result.valid       = 1'b1;
                result.left_speed  = {captured_reg[1], captured_reg[0]};
                result.right_speed = {captured_reg[3], captured_reg[2]};
                result.ctrl_flag   = captured_reg[4];
                result.status      = crc8fr_pkg::STATUS_OK;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // Hold frame state, advance on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= crc8fr_pkg::PH_HUNT;
            previous_byte_reg <= 8'd0;
            frame_length_reg  <= 8'd0;
            payload_count_reg <= 8'd0;
            running_crc_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            previous_byte_reg <= previous_byte_next;
            frame_length_reg  <= frame_length_next;
            payload_count_reg <= payload_count_next;
            running_crc_reg   <= running_crc_next;
        end
    end

    // Capture payload bytes 0 to 4, drop the rest
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                captured_reg[i] <= 8'd0;
            end
        end
        else if (step && (phase_reg == crc8fr_pkg::PH_PAYLOAD) &&
                 (payload_count_reg < crc8fr_pkg::CAPTURE_LEN))
        begin
            captured_reg[payload_count_reg[2:0]] <= rx_byte;
        end
    end

`ifndef NO_ASSERTIONS
    a_result_only_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (phase_reg == crc8fr_pkg::PH_CRC) ||
                         (phase_reg == crc8fr_pkg::PH_TRAIL1))
        else $error("result outside CRC or trailer phase");
    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.valid |=> (phase_reg == crc8fr_pkg::PH_HUNT) &&
                                 (running_crc_reg == 8'd0) && (previous_byte_reg == 8'd0))
        else $error("frame end did not return to hunting");
    a_payload_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == crc8fr_pkg::PH_PAYLOAD) |-> (payload_count_reg < frame_length_reg))
        else $error("payload count overran frame length");
`endif

endmodule

>>> rtl/crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver
// CRC-8 framed serial receiver: one byte per input transaction, one result
// transaction per completed or dropped frame.
// ----------------------------------------------------------------------------
// Each received byte is held in an input register, where the frame tracker
// and the unrolled eight-step CRC update process it, and any result lands in
// an output register. One byte is accepted every cycle while the output side
// keeps up; a waiting result stalls the input only when the byte in the input
// register would cause another result.
module crc8_frame_receiver (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] left_speed,
    output logic signed [15:0] right_speed,
    output logic [7:0]         ctrl_flag,
    output logic               status
);

    logic                in_valid_reg;
    logic [7:0]          byte_reg;
    logic                out_valid_reg;
    logic [15:0]         left_reg;
    logic [15:0]         right_reg;
    logic [7:0]          flag_reg;
    logic                status_reg;
    logic                advance;
    crc8fr_pkg::result_t res;

    crc8fr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (byte_reg),
        .result  (res)
    );

    // Process the held byte unless its result has nowhere to go
    assign advance  = in_valid_reg && (!res.valid || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

    // Output register: load a new result, drop a taken one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            left_reg   <= res.left_speed;
            right_reg  <= res.right_speed;
            flag_reg   <= res.ctrl_flag;
            status_reg <= res.status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_speed  = $signed(left_reg);
    assign right_speed = $signed(right_reg);
    assign ctrl_flag   = flag_reg;
    assign status      = status_reg;

`ifndef NO_ASSERTIONS
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.valid |=> out_valid)
        else $error("result lost on its way to the output register");
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready && res.valid)
        else $error("input stalled without a blocked result");
    a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == crc8fr_pkg::STATUS_CRC_ERR) |->
            (left_speed == 16'sd0) && (right_speed == 16'sd0) && (ctrl_flag == 8'd0))
        else $error("CRC error transaction carries payload");
`endif

endmodule

>>> dv/crc8_frame_receiver_checker.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver_checker
// Watches both channels of the frame receiver, decodes each accepted byte
// with an independent frame tracker and CRC-8, and compares every result
// transaction field by field with the oldest outstanding frame result.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] left_speed,
    input  logic signed [15:0] right_speed,
    input  logic [7:0]         ctrl_flag,
    input  logic               status,
    output int                 mismatch_count,
    output int                 frames_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [7:0]         ctrl_flag;
        logic               status;
    } frame_result_t;

    // Tracker state
    crc8fr_pkg::phase_t rx_phase = crc8fr_pkg::PH_HUNT;
    logic [7:0]    last_byte  = 8'h00;
    logic [7:0]    frame_len  = 8'h00;
    logic [7:0]    byte_count = 8'h00;
    logic [7:0]    crc_acc    = 8'h00;
    logic [7:0]    captured [0:4];
    frame_result_t expected_frames [$];
    int            error_total   = 0;
    int            pending_total = 0;

    assign mismatch_count = error_total;
    assign frames_pending = pending_total;

    // Shift one byte through the reflected CRC, LSB first
    function automatic logic [7:0] crc_update(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        repeat (8)
        begin
            r = {1'b0, r[7:1]} ^ (r[0] ? crc8fr_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    // Drop back to header hunting with a clean frame context
    function automatic void restart_hunt();
        rx_phase   = crc8fr_pkg::PH_HUNT;
        last_byte  = 8'h00;
        frame_len  = 8'h00;
        byte_count = 8'h00;
        crc_acc    = 8'h00;
    endfunction

    // Advance the tracker by one byte; flag a result when a frame closes
    function automatic void decode_byte(input logic [7:0] b, output bit emitted,
                                        output frame_result_t res);
        emitted = 1'b0;
        res     = '0;
        case (rx_phase)
            crc8fr_pkg::PH_LEN:
            begin
                frame_len  = b;
                crc_acc    = crc_update(crc_acc, b);
                byte_count = 8'h00;
                rx_phase   = (b == 8'h00) ? crc8fr_pkg::PH_CRC : crc8fr_pkg::PH_PAYLOAD;
            end
            crc8fr_pkg::PH_PAYLOAD:
            begin
                if (byte_count < crc8fr_pkg::CAPTURE_LEN)
                begin
                    captured[byte_count[2:0]] = b;
                end
                crc_acc    = crc_update(crc_acc, b);
                byte_count = byte_count + 8'd1;
                if (byte_count >= frame_len)
                begin
                    rx_phase = crc8fr_pkg::PH_CRC;
                end
            end
            crc8fr_pkg::PH_CRC:
            begin
                if (b != crc_acc)
                begin
                    emitted    = 1'b1;
                    res.status = crc8fr_pkg::STATUS_CRC_ERR;
                    restart_hunt();
                end
                else
                begin
                    rx_phase = crc8fr_pkg::PH_TRAIL0;
                end
            end
            crc8fr_pkg::PH_TRAIL0:
            begin
                rx_phase = crc8fr_pkg::PH_TRAIL1;
            end
            crc8fr_pkg::PH_TRAIL1:
            begin
                emitted         = 1'b1;
                res.left_speed  = {captured[1], captured[0]};
                res.right_speed = {captured[3], captured[2]};
                res.ctrl_flag   = captured[4];
                res.status      = crc8fr_pkg::STATUS_OK;
                restart_hunt();
            end
            default:
            begin
                // a second header byte never overwrites the remembered byte
                if (b == crc8fr_pkg::HDR1)
                begin
                    if (last_byte == crc8fr_pkg::HDR0)
                    begin
                        rx_phase   = crc8fr_pkg::PH_LEN;
                        crc_acc    = crc_update(crc_update(8'h00, crc8fr_pkg::HDR0),
                                                crc8fr_pkg::HDR1);
                        byte_count = 8'h00;
                    end
                end
                else
                begin
                    last_byte = b;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string what, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            error_total++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t res;
        frame_result_t want;
        bit            emitted;
        if (!rst_n)
        begin
            restart_hunt();
            foreach (captured[i])
            begin
                captured[i] = 8'h00;
            end
            expected_frames.delete();
        end
        else
        begin
            // compare the result transaction before taking in the new byte
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    error_total++;
                    $display("%0t: unexpected result, expected none, actual %h %h %h %b",
                             $time, left_speed, right_speed, ctrl_flag, status);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("left_speed", want.left_speed, left_speed);
                    check_field("right_speed", want.right_speed, right_speed);
                    check_field("ctrl_flag", {8'h00, want.ctrl_flag}, {8'h00, ctrl_flag});
                    check_field("status", {15'h0000, want.status}, {15'h0000, status});
                end
            end
            // predict from the accepted byte transaction
            if (in_valid && in_ready)
            begin
                decode_byte(rx_byte, emitted, res);
                if (emitted)
                begin
                    expected_frames.push_back(res);
                end
            end
        end
        pending_total = expected_frames.size();
    end

endmodule

>>> dv/crc8_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver_tb
// Feeds framed and noisy byte streams into the CRC-8 frame receiver under
// several sender and receiver idling patterns and gives the verdict from the
// checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [7:0] byte_q_t [$];

    localparam int FRAME_BYTES_TARGET = 2000;
    localparam int LONG_HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES       = 20;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [7:0]         ctrl_flag;
    logic               status;
    int                 mismatch_count;
    int                 frames_pending;

    int frame_bytes    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;

    crc8_frame_receiver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .ctrl_flag   (ctrl_flag),
        .status      (status)
    );

    crc8_frame_receiver_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_speed     (left_speed),
        .right_speed    (right_speed),
        .ctrl_flag      (ctrl_flag),
        .status         (status),
        .mismatch_count (mismatch_count),
        .frames_pending (frames_pending)
    );

    always #10 clk = ~clk;

    // Frame CRC for building good frames
    function automatic logic [7:0] frame_crc(input byte_q_t bytes_q);
        logic [7:0] acc;
        acc = 8'h00;
        foreach (bytes_q[i])
        begin
            acc = acc ^ bytes_q[i];
            repeat (8)
            begin
                acc = acc[0] ? ((acc >> 1) ^ crc8fr_pkg::CRC_POLY) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    function automatic byte_q_t random_body(input int len);
        byte_q_t body;
        repeat (len)
        begin
            body.push_back(8'($urandom));
        end
        return body;
    endfunction

    // Offer one byte, idling first at the current rate, and hold until taken
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Build header, length, payload, CRC and trailers; optionally corrupt the
    // CRC or cut the frame short after keep bytes
    task automatic send_frame(input byte_q_t body, input bit bad_crc, input int keep);
        byte_q_t    bytes_q;
        logic [7:0] crc;
        bytes_q = {};
        bytes_q.push_back(crc8fr_pkg::HDR0);
        bytes_q.push_back(crc8fr_pkg::HDR1);
        bytes_q.push_back(8'(body.size()));
        foreach (body[i])
        begin
            bytes_q.push_back(body[i]);
        end
        crc = frame_crc(bytes_q);
        if (bad_crc)
        begin
            crc = crc ^ 8'($urandom_range(255, 1));
        end
        bytes_q.push_back(crc);
        bytes_q.push_back(8'($urandom));
        bytes_q.push_back(8'($urandom));
        while (keep >= 0 && bytes_q.size() > keep)
        begin
            void'(bytes_q.pop_back());
        end
        foreach (bytes_q[i])
        begin
            send_byte(bytes_q[i]);
        end
        frame_bytes += bytes_q.size();
    endtask

    // Line noise rich in header bytes
    task automatic send_noise();
        int n;
        n = $urandom_range(4, 1);
        repeat (n)
        begin
            case ($urandom_range(2))
                0:       send_byte(crc8fr_pkg::HDR0);
                1:       send_byte(crc8fr_pkg::HDR1);
                default: send_byte(8'($urandom));
            endcase
        end
        frame_bytes += n;
    endtask

    // Receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                out_ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD_CYCLES; n++)
                begin
                    @(posedge clk);
                end
                hold_done = 1'b1;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus and verdict
    initial
    begin
        byte_q_t pattern;
        int      pick;
        int      len;
        int      keep;
        bit      bad;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = 8'h00;
        repeat (7)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        // no header: 0xaa with 0x12 remembered, then a frame of extreme speeds
        send_byte(crc8fr_pkg::HDR1);
        send_byte(crc8fr_pkg::HDR0);
        send_byte(8'h12);
        send_byte(crc8fr_pkg::HDR1);
        frame_bytes += 4;
        pattern = {8'h00, 8'h80, 8'hff, 8'h7f, 8'h00};
        send_frame(pattern, 1'b0, -1);
        pattern = {8'hff, 8'h7f, 8'h00, 8'h80, 8'hff};
        send_frame(pattern, 1'b0, -1);
        // zero length and short payloads keep older captured bytes
        pattern = {};
        send_frame(pattern, 1'b0, -1);
        pattern = {8'h01, 8'hfe};
        send_frame(pattern, 1'b0, -1);
        // a lone 0xaa after a frame must not open a new one
        send_byte(crc8fr_pkg::HDR1);
        frame_bytes += 1;
        // long payload: only the first five bytes are captured
        send_frame(random_body(8), 1'b0, -1);
        send_frame(random_body(5), 1'b1, -1);
        pattern = {8'hff};
        send_frame(pattern, 1'b1, -1);
        // header then 0xaa taken as the length byte
        send_frame(random_body(170), 1'b0, -1);
        send_frame(random_body(3), 1'b0, 5);
        send_frame(random_body(5), 1'b0, -1);

        // random frames across the idling phases
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_request   = 1'b1;
                end
                1:
                begin
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                end
                default:
                begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 32;
                end
            endcase
            while (frame_bytes < (FRAME_BYTES_TARGET * (p + 1)) / 4)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    send_noise();
                end
                else
                begin
                    len  = ($urandom_range(99) == 0) ? $urandom_range(255, 9)
                                                     : $urandom_range(8);
                    bad  = ($urandom_range(99) < 15);
                    keep = ($urandom_range(99) < 8) ? $urandom_range(len + 5, 3) : -1;
                    send_frame(random_body(len), bad, keep);
                end
            end
        end
        in_valid <= 1'b0;

        // drain outstanding frame results, then let stray outputs show
        do
        begin
            @(posedge clk);
        end
        while (frames_pending != 0);
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0 && frames_pending == 0)
        begin
            $display("crc8_frame_receiver regression: pass");
        end
        else
        begin
            $display("crc8_frame_receiver regression: fail");
        end
        $finish;
    end

    // Hang guard
    initial
    begin
        #10_000_000;
        $display("crc8_frame_receiver regression: fail");
        $finish;
    end

endmodule
